// ----- hw/rtl/cbr_pkg.sv -----
// ----------------------------------------------------------------------------
// cbr_pkg
// Shared types and constants of the streaming convolution with bias and ReLU.
// ----------------------------------------------------------------------------
package cbr_pkg;

  localparam int PIX_W      = 16;   // pixel and weight sample width
  localparam int PROD_W     = 28;   // product after the arithmetic shift by four
  localparam int OUT_W      = 31;   // rectified result width
  localparam int IDX_W      = 10;   // reported row and column width
  localparam int KDIM_W     = 4;    // kernel coordinates and size
  localparam int DIM_W_H    = 11;   // image height and width register width
  localparam int ROW_LIMIT  = 1024;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BIAS   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 4'd3;

  localparam logic CMD_PIXEL = 1'b1;

  // Control and payload of one request as it moves down the pipeline.
  typedef struct packed {
    logic              valid;
    logic              pixel;
    logic              emit;
    logic              last;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [KDIM_W-1:0] row_lim;
    logic [KDIM_W-1:0] col_lim;
    logic [KDIM_W-1:0] wrow;
    logic [KDIM_W-1:0] wcol;
    logic [PIX_W-1:0]  value;
  } stage_t;

endpackage

// ----- hw/rtl/cbr_in_if.sv -----
// ----------------------------------------------------------------------------
// cbr_in_if
// Input request channel: weight loads and image pixels.
// ----------------------------------------------------------------------------
interface cbr_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [3:0]         weight_row;
  logic [3:0]         weight_col;
  logic signed [15:0] sample_value;

  modport source(output valid, command, weight_row, weight_col, sample_value,
                 input ready);
  modport sink(input valid, command, weight_row, weight_col, sample_value,
               output ready);
endinterface

// ----- hw/rtl/cbr_out_if.sv -----
// ----------------------------------------------------------------------------
// cbr_out_if
// Result channel: rectified outputs with their position.
// ----------------------------------------------------------------------------
interface cbr_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] result_value;
  logic [9:0]  out_row;
  logic [9:0]  out_col;
  logic        last_of_frame;

  modport source(output valid, result_value, out_row, out_col, last_of_frame,
                 input ready);
  modport sink(input valid, result_value, out_row, out_col, last_of_frame,
               output ready);
endinterface

// ----- hw/rtl/cbr_cfg_if.sv -----
// ----------------------------------------------------------------------------
// cbr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface cbr_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- hw/rtl/cbr_line_buf.sv -----
// ----------------------------------------------------------------------------
// cbr_line_buf
// Column memory holding the previous rows of every image column, updated by
// read, shift and write back, with forwarding for back-to-back same column.
// ----------------------------------------------------------------------------
module cbr_line_buf
  import cbr_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 11
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_col,
  input  logic                    wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
  input  logic [PIX_W-1:0]        pixel,
  output logic [PIX_W-1:0]        colvec [MAX_KERNEL]
);

  localparam int LB_ROWS = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int WORD_W  = LB_ROWS * PIX_W;

  logic [WORD_W-1:0] mem [MAX_WIDTH];
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] fwd_word;
  logic              fwd_hit;
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] wr_word;
  logic [PIX_W-1:0]  col_full [LB_ROWS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rdata <= mem[rd_col];
      if (wr_en) begin
        mem[wr_col] <= wr_word;
      end
      fwd_word <= wr_word;
    end
  end

  // A write at the same edge as the read of that column is not yet visible
  // in the read data, so the written word is taken instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (en) begin
      fwd_hit <= wr_en && (wr_col == rd_col);
    end
  end

  assign rd_word = fwd_hit ? fwd_word : rdata;

  always_comb begin
    col_full[0] = pixel;
    for (int i = 0; i < LB_ROWS; i++) begin
      col_full[i+1]              = rd_word[i*PIX_W +: PIX_W];
      wr_word[i*PIX_W +: PIX_W]  = col_full[i];
    end
    for (int i = 0; i < MAX_KERNEL; i++) begin
      colvec[i] = col_full[i];
    end
  end

endmodule

// ----- hw/rtl/cbr_mac_array.sv -----
// ----------------------------------------------------------------------------
// cbr_mac_array
// Window register, weight registers, product array, registered adder tree,
// bias addition, saturation and rectification.
// ----------------------------------------------------------------------------
module cbr_mac_array
  import cbr_pkg::*;
#(
  parameter int MAX_KERNEL = 11
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  stage_t                  s1,
  input  logic [PIX_W-1:0]        colvec [MAX_KERNEL],
  input  logic [KDIM_W-1:0]       k_eff,
  input  logic signed [31:0]      bias,
  output stage_t                  res_ctl,
  output logic [OUT_W-1:0]        res_value
);

  localparam int N     = MAX_KERNEL * MAX_KERNEL;
  localparam int L1    = (N + 3) / 4;
  localparam int L2    = (L1 + 3) / 4;
  localparam int L3    = (L2 + 3) / 4;
  localparam int L4    = (L3 + 3) / 4;
  localparam int SUM_W = 34 + $clog2(N);
  localparam int WI_W  = (N > 1) ? $clog2(N) : 1;
  localparam logic signed [SUM_W-1:0] SAT_MAX = {{(SUM_W-31){1'b0}}, {31{1'b1}}};

  logic signed [PIX_W-1:0]   win [MAX_KERNEL][MAX_KERNEL];
  logic signed [PIX_W-1:0]   wgt [N];
  logic signed [2*PIX_W-1:0] mulres [N];
  logic signed [PROD_W-1:0]  prod [N];
  logic [N-1:0]              mask_next;
  logic [N-1:0]              s2_mask;
  logic [WI_W-1:0]           widx;
  logic signed [SUM_W-1:0]   sum1 [L1];
  logic signed [SUM_W-1:0]   sum2 [L2];
  logic signed [SUM_W-1:0]   sum3 [L3];
  logic signed [SUM_W-1:0]   sum4 [L4];
  logic signed [SUM_W-1:0]   t1 [L1];
  logic signed [SUM_W-1:0]   t2 [L2];
  logic signed [SUM_W-1:0]   t3 [L3];
  logic signed [SUM_W-1:0]   t4 [L4];
  logic signed [SUM_W-1:0]   total;
  stage_t                    s2, s3, m1, m2, m3, m4;
  stage_t                    res_next;

  // Taps outside the kernel, above the first row or left of the first
  // column contribute nothing.
  always_comb begin
    for (int i = 0; i < MAX_KERNEL; i++) begin
      for (int j = 0; j < MAX_KERNEL; j++) begin
        mask_next[i*MAX_KERNEL+j] = (KDIM_W'(i) < k_eff) && (KDIM_W'(j) < k_eff) &&
                                    (KDIM_W'(i) <= s1.row_lim) &&
                                    (KDIM_W'(j) <= s1.col_lim);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1.valid && s1.pixel) begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
        win[i][0] <= colvec[i];
        for (int j = 1; j < MAX_KERNEL; j++) begin
          win[i][j] <= win[i][j-1];
        end
      end
    end
    if (en) begin
      s2_mask <= mask_next;
    end
  end

  assign widx = WI_W'(int'(s2.wrow) * MAX_KERNEL + int'(s2.wcol));

  // Weights are written at the product stage so that every pixel sees the
  // kernel as it stood when it was accepted.
  always_ff @(posedge clk) begin
    if (en && s2.valid && !s2.pixel && (s2.wrow < KDIM_W'(MAX_KERNEL)) &&
        (s2.wcol < KDIM_W'(MAX_KERNEL))) begin
      wgt[widx] <= s2.value;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_KERNEL; i++) begin
      for (int j = 0; j < MAX_KERNEL; j++) begin
        mulres[i*MAX_KERNEL+j] = win[i][j] * wgt[i*MAX_KERNEL+j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < N; n++) begin
        prod[n] <= (s2.valid && s2.pixel && s2_mask[n]) ? mulres[n][2*PIX_W-1:4] : '0;
      end
    end
  end

  always_comb begin
    for (int g = 0; g < L1; g++) begin
      sum1[g] = '0;
      for (int q = 0; q < 4; q++) begin
        if (g*4 + q < N) sum1[g] = sum1[g] + SUM_W'(prod[g*4+q]);
      end
    end
    for (int g = 0; g < L2; g++) begin
      sum2[g] = '0;
      for (int q = 0; q < 4; q++) begin
        if (g*4 + q < L1) sum2[g] = sum2[g] + t1[g*4+q];
      end
    end
    for (int g = 0; g < L3; g++) begin
      sum3[g] = '0;
      for (int q = 0; q < 4; q++) begin
        if (g*4 + q < L2) sum3[g] = sum3[g] + t2[g*4+q];
      end
    end
    for (int g = 0; g < L4; g++) begin
      sum4[g] = '0;
      for (int q = 0; q < 4; q++) begin
        if (g*4 + q < L3) sum4[g] = sum4[g] + t3[g*4+q];
      end
    end
  end

  assign total = t4[0] + SUM_W'(bias);

  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= sum1;
      t2 <= sum2;
      t3 <= sum3;
      t4 <= sum4;
      if (total < 0) begin
        res_value <= '0;
      end else if (total > SAT_MAX) begin
        res_value <= '1;
      end else begin
        res_value <= total[OUT_W-1:0];
      end
    end
  end

  always_comb begin
    res_next       = m4;
    res_next.valid = m4.valid && m4.pixel && m4.emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2      <= '0;
      s3      <= '0;
      m1      <= '0;
      m2      <= '0;
      m3      <= '0;
      m4      <= '0;
      res_ctl <= '0;
    end else if (en) begin
      s2      <= s1;
      s3      <= s2;
      m1      <= s3;
      m2      <= m1;
      m3      <= m2;
      m4      <= m3;
      res_ctl <= res_next;
    end
  end

endmodule

// ----- hw/rtl/conv2d_bias_relu.sv -----
// ----------------------------------------------------------------------------
// conv2d_bias_relu
// Streaming square-kernel convolution with bias, saturation and ReLU.
// A pixel request passes the input, window, product, adder tree and output registers before its result shows.
// Throughput: one request per cycle when not stalled, set by the single
// read-modify-write of the column memory per pixel and a fully parallel product array.
// The pipeline advances whenever the output register is empty or being taken.
// Reset clears the pipeline, position and registers (bias 0, 1024 x 1024,
// kernel 3); weights and line memory hold nothing defined until written.
// ----------------------------------------------------------------------------
module conv2d_bias_relu
  import cbr_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 11
) (
  input logic     clk,
  input logic     rst,
  cbr_in_if.sink  in_ch,
  cbr_out_if.source out_ch,
  cbr_cfg_if.sink cfg_ch
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int DIM_W = (COL_W + 1 > DIM_W_H) ? COL_W + 1 : DIM_W_H;
  localparam logic [KDIM_W-1:0] LIM_MAX = '1;

  logic signed [31:0]   bias_value;
  logic [DIM_W_H-1:0]   image_width;
  logic [DIM_W_H-1:0]   image_height;
  logic [KDIM_W-1:0]    kernel_size;
  logic [IDX_W-1:0]     row_pos;
  logic [COL_W-1:0]     col_pos;

  logic [DIM_W-1:0]     w_eff;
  logic [DIM_W_H-1:0]   h_eff;
  logic [KDIM_W-1:0]    k_eff;
  logic [COL_W-1:0]     c_use;
  logic [IDX_W-1:0]     r_use;
  logic [DIM_W-1:0]     c_inc;
  logic [DIM_W_H-1:0]   r_inc;
  logic [COL_W-1:0]     col_pos_next;
  logic [IDX_W-1:0]     row_pos_next;
  logic                 fits, emit, last;
  logic                 en, in_acc, cfg_acc;
  stage_t               s0, s1, res_ctl;
  logic [COL_W-1:0]     s1_col;
  logic [PIX_W-1:0]     colvec [MAX_KERNEL];
  logic [OUT_W-1:0]     res_value;

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid;
  assign en           = !res_ctl.valid || out_ch.ready;
  assign in_ch.ready  = en;
  assign in_acc       = in_ch.valid && en;

  always_comb begin
    if (image_width == '0) w_eff = DIM_W'(1);
    else if (DIM_W'(image_width) > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
    else w_eff = DIM_W'(image_width);

    if (image_height == '0) h_eff = DIM_W_H'(1);
    else if (image_height > DIM_W_H'(ROW_LIMIT)) h_eff = DIM_W_H'(ROW_LIMIT);
    else h_eff = image_height;

    if (kernel_size == '0) k_eff = KDIM_W'(1);
    else if (kernel_size > KDIM_W'(MAX_KERNEL)) k_eff = KDIM_W'(MAX_KERNEL);
    else k_eff = kernel_size;
  end

  always_comb begin
    c_use = (DIM_W'(col_pos) >= w_eff) ? '0 : col_pos;
    r_use = (DIM_W_H'(row_pos) >= h_eff) ? '0 : row_pos;
    fits  = (DIM_W'(k_eff) <= w_eff) && (DIM_W_H'(k_eff) <= h_eff);
    emit  = fits && (DIM_W_H'(r_use) <= h_eff - DIM_W_H'(k_eff)) &&
            (DIM_W'(c_use) <= w_eff - DIM_W'(k_eff));
    last  = fits && (DIM_W_H'(r_use) == h_eff - DIM_W_H'(k_eff)) &&
            (DIM_W'(c_use) == w_eff - DIM_W'(k_eff));

    c_inc = DIM_W'(c_use) + DIM_W'(1);
    r_inc = DIM_W_H'(r_use) + DIM_W_H'(1);
    if (c_inc >= w_eff) begin
      col_pos_next = '0;
      row_pos_next = (r_inc >= h_eff) ? '0 : r_inc[IDX_W-1:0];
    end else begin
      col_pos_next = c_inc[COL_W-1:0];
      row_pos_next = r_use;
    end
  end

  // Any size change starts a new frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      bias_value   <= '0;
      image_width  <= DIM_W_H'(1024);
      image_height <= DIM_W_H'(1024);
      kernel_size  <= KDIM_W'(3);
      row_pos      <= '0;
      col_pos      <= '0;
    end else if (cfg_acc) begin
      unique case (cfg_ch.index)
        CFG_BIAS: bias_value <= cfg_ch.data;
        CFG_WIDTH: begin
          image_width <= cfg_ch.data[DIM_W_H-1:0];
          row_pos     <= '0;
          col_pos     <= '0;
        end
        CFG_HEIGHT: begin
          image_height <= cfg_ch.data[DIM_W_H-1:0];
          row_pos      <= '0;
          col_pos      <= '0;
        end
        CFG_KERNEL: begin
          kernel_size <= cfg_ch.data[KDIM_W-1:0];
          row_pos     <= '0;
          col_pos     <= '0;
        end
        default: ;
      endcase
    end else if (in_acc && (in_ch.command == CMD_PIXEL)) begin
      row_pos <= row_pos_next;
      col_pos <= col_pos_next;
    end
  end

  always_comb begin
    s0.valid   = in_acc;
    s0.pixel   = (in_ch.command == CMD_PIXEL);
    s0.emit    = emit;
    s0.last    = last;
    s0.row     = r_use;
    s0.col     = IDX_W'(c_use);
    s0.row_lim = (r_use > IDX_W'(LIM_MAX)) ? LIM_MAX : r_use[KDIM_W-1:0];
    s0.col_lim = (c_use > COL_W'(LIM_MAX)) ? LIM_MAX : c_use[KDIM_W-1:0];
    s0.wrow    = in_ch.weight_row;
    s0.wcol    = in_ch.weight_col;
    s0.value   = in_ch.sample_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (en) begin
      s1 <= s0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_col <= c_use;
    end
  end

  cbr_line_buf #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_KERNEL(MAX_KERNEL)
  ) u_line_buf (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .rd_col(c_use),
    .wr_en (s1.valid && s1.pixel),
    .wr_col(s1_col),
    .pixel (s1.value),
    .colvec(colvec)
  );

  cbr_mac_array #(
    .MAX_KERNEL(MAX_KERNEL)
  ) u_mac_array (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .s1       (s1),
    .colvec   (colvec),
    .k_eff    (k_eff),
    .bias     (bias_value),
    .res_ctl  (res_ctl),
    .res_value(res_value)
  );

  assign out_ch.valid         = res_ctl.valid;
  assign out_ch.result_value  = res_value;
  assign out_ch.out_row       = res_ctl.row;
  assign out_ch.out_col       = res_ctl.col;
  assign out_ch.last_of_frame = res_ctl.last;

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    DIM_W'(col_pos) < w_eff)
    else $error("column position beyond the image width");

  a_last_col: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.last_of_frame |->
      out_ch.out_col == IDX_W'(w_eff - DIM_W'(k_eff)))
    else $error("end of frame flagged away from the last output column");

  a_kernel_fits: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (DIM_W'(k_eff) <= w_eff) && (DIM_W_H'(k_eff) <= h_eff))
    else $error("result shown although the kernel exceeds the image");

endmodule

// ----- test/tb_conv2d_bias_relu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv2d_bias_relu
// Self-checking bench for the streaming convolution with bias and ReLU. All weights are loaded
// first, then a directed table of weight loads and pixels, then random frames of varied size,
// kernel and bias. Table rows that carry a result are checked against it, every other result is
// compared with a software image of the weights and line memory, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_conv2d_bias_relu;
  import cbr_pkg::*;

  localparam logic CMD_WEIGHT = 1'b0;
  localparam int   KMAX       = 11;
  localparam int   WMAX       = 1024;
  localparam int   RANDOM_ITEMS = 1500;
  localparam int   CYCLE_LIMIT  = 2000000;
  localparam int   SETTLE       = 16;

  typedef struct {
    logic [30:0] value;
    logic [9:0]  row;
    logic [9:0]  col;
    logic        last;
  } conv_out_t;

  typedef struct {
    logic        cmd;
    logic [3:0]  wrow;
    logic [3:0]  wcol;
    logic [15:0] sample;
    logic        typed;
    conv_out_t   res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cbr_in_if  in_ch ();
  cbr_out_if out_ch ();
  cbr_cfg_if cfg_ch ();

  conv2d_bias_relu dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  // Software image of the block.
  logic signed [15:0] kern_img [KMAX][KMAX];
  logic signed [15:0] line_img [KMAX][WMAX];
  longint             bias_img;
  int unsigned        width_img, height_img, ksize_img;
  int unsigned        row_pos, col_pos;

  conv_out_t  pending_q[$];
  int         errors = 0;
  int         cycles = 0;
  bit         stalls_on = 1'b1;
  int         hold_cnt = 0;
  int         sent = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_WEIGHT;
    in_ch.weight_row = '0;
    in_ch.weight_col = '0;
    in_ch.sample_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_BIAS;
    cfg_ch.data = '0;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic apply_cfg(logic [3:0] idx, logic [31:0] data);
    if (idx == CFG_BIAS) begin
      bias_img = longint'(signed'(data));
      return;
    end
    if (idx == CFG_WIDTH) width_img = data[10:0];
    else if (idx == CFG_HEIGHT) height_img = data[10:0];
    else if (idx == CFG_KERNEL) ksize_img = data[3:0];
    else return;
    row_pos = 0;
    col_pos = 0;
  endtask

  // Updates the image for one accepted request; returns 1 when a result is due.
  function automatic bit conv_predict(logic cmd, logic [3:0] wr, logic [3:0] wc,
                                      logic [15:0] v, output conv_out_t res);
    int unsigned w, h, k, r, c;
    longint acc, p;
    w = clamp_dim(width_img, WMAX);
    h = clamp_dim(height_img, 1024);
    k = clamp_dim(ksize_img, KMAX);
    r = row_pos;
    c = col_pos;
    res = '{default: '0};
    if (cmd == CMD_WEIGHT) begin
      if (wr < KMAX && wc < KMAX) kern_img[wr][wc] = v;
      return 1'b0;
    end
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    line_img[r % KMAX][c] = v;
    conv_predict = 1'b0;
    if (k <= w && k <= h && r <= h - k && c <= w - k) begin
      acc = bias_img;
      for (int i = 0; i < k && i <= r; i++)
        for (int j = 0; j < k && j <= c; j++) begin
          p = longint'(line_img[(r - i) % KMAX][c - j]) * longint'(kern_img[i][j]);
          acc += p >>> 4;
        end
      if (acc > 64'sh7FFFFFFF) acc = 64'sh7FFFFFFF;
      if (acc < 0) acc = 0;
      res.value = acc[30:0];
      res.row = r[9:0];
      res.col = c[9:0];
      res.last = (r == h - k && c == w - k);
      conv_predict = 1'b1;
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endfunction

  task automatic send_req(logic cmd, logic [3:0] wr, logic [3:0] wc, logic [15:0] v,
                          bit typed = 1'b0, conv_out_t typed_res = '{default: '0});
    conv_out_t res;
    int gap;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.command = cmd;
    in_ch.weight_row = wr;
    in_ch.weight_col = wc;
    in_ch.sample_value = v;
    do @(posedge clk); while (!in_ch.ready);
    if (conv_predict(cmd, wr, wc, v, res)) pending_q.push_back(typed ? typed_res : res);
    sent++;
    if (stalls_on && $urandom_range(99) < 25) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Lets the pipeline empty before a register is touched.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = data;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_cfg(idx, data);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(32)) - 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  // Result sink with short and occasional long stalls.
  always @(negedge clk) begin
    if (!stalls_on) begin
      out_ch.ready <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(99) < 20) begin
      hold_cnt <= ($urandom_range(19) == 0) ? $urandom_range(60, 15) : $urandom_range(3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    conv_out_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result value %h row %0d col %0d", $time,
                 out_ch.result_value, out_ch.out_row, out_ch.out_col);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (out_ch.result_value !== want.value) begin
          $display("%0t: result_value expected %h actual %h", $time, want.value,
                   out_ch.result_value);
          errors++;
        end
        if (out_ch.out_row !== want.row) begin
          $display("%0t: out_row expected %0d actual %0d", $time, want.row, out_ch.out_row);
          errors++;
        end
        if (out_ch.out_col !== want.col) begin
          $display("%0t: out_col expected %0d actual %0d", $time, want.col, out_ch.out_col);
          errors++;
        end
        if (out_ch.last_of_frame !== want.last) begin
          $display("%0t: last_of_frame expected %b actual %b", $time, want.last,
                   out_ch.last_of_frame);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_conv2d_bias_relu: done, errors");
      $finish;
    end
  end

  // Directed rows on a 2 x 2 image with a 1 x 1 kernel and zero bias.
  stim_row_t stim_tab[] = '{
    '{CMD_WEIGHT, 4'd0, 4'd0, 16'h7FFF, 1'b0, '{default: '0}},
    '{CMD_PIXEL, 4'd0, 4'd0, 16'h7FFF, 1'b1, '{31'd67104768, 10'd0, 10'd0, 1'b0}},
    '{CMD_PIXEL, 4'd9, 4'd5, 16'h8000, 1'b1, '{31'd0, 10'd0, 10'd1, 1'b0}},
    '{CMD_WEIGHT, 4'd0, 4'd0, 16'h8000, 1'b0, '{default: '0}},
    '{CMD_WEIGHT, 4'd15, 4'd15, 16'h1234, 1'b0, '{default: '0}},
    '{CMD_WEIGHT, 4'd11, 4'd3, 16'hFFFF, 1'b0, '{default: '0}},
    '{CMD_WEIGHT, 4'd3, 4'd11, 16'hFFFF, 1'b0, '{default: '0}},
    '{CMD_WEIGHT, 4'd10, 4'd10, 16'h4321, 1'b0, '{default: '0}},
    '{CMD_PIXEL, 4'd0, 4'd0, 16'h8000, 1'b1, '{31'd67108864, 10'd1, 10'd0, 1'b0}},
    '{CMD_PIXEL, 4'd0, 4'd0, 16'h0000, 1'b1, '{31'd0, 10'd1, 10'd1, 1'b1}},
    '{CMD_PIXEL, 4'd0, 4'd0, 16'h0001, 1'b1, '{31'd0, 10'd0, 10'd0, 1'b0}},
    '{CMD_WEIGHT, 4'd0, 4'd0, 16'h0001, 1'b0, '{default: '0}},
    '{CMD_PIXEL, 4'd0, 4'd0, 16'hFFFF, 1'b1, '{31'd0, 10'd0, 10'd1, 1'b0}},
    '{CMD_PIXEL, 4'd0, 4'd0, 16'h0010, 1'b1, '{31'd1, 10'd1, 10'd0, 1'b0}},
    '{CMD_PIXEL, 4'd0, 4'd0, 16'h000F, 1'b1, '{31'd0, 10'd1, 10'd1, 1'b1}},
    '{CMD_PIXEL, 4'd0, 4'd0, 16'h1234, 1'b0, '{default: '0}}
  };

  initial begin
    int unsigned fw, fh, npix;
    logic [31:0] d;
    bias_img = 0;
    width_img = 1024;
    height_img = 1024;
    ksize_img = 3;
    row_pos = 0;
    col_pos = 0;
    foreach (kern_img[i, j]) kern_img[i][j] = '0;
    foreach (line_img[i, j]) line_img[i][j] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Every weight gets a defined value before any window can read it.
    for (int i = 0; i < KMAX; i++)
      for (int j = 0; j < KMAX; j++)
        send_req(CMD_WEIGHT, 4'(i), 4'(j), pick_sample());
    drain();
    write_reg(CFG_BIAS, 32'd0);
    write_reg(CFG_WIDTH, 32'd2);
    write_reg(CFG_HEIGHT, 32'd2);
    write_reg(CFG_KERNEL, 32'd1);
    foreach (stim_tab[n])
      send_req(stim_tab[n].cmd, stim_tab[n].wrow, stim_tab[n].wcol, stim_tab[n].sample,
               stim_tab[n].typed, stim_tab[n].res);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      stalls_on = ($urandom_range(4) != 0);
      if ($urandom_range(1)) begin
        case ($urandom_range(4))
          0: d = 32'h7FFFFFFF;
          1: d = 32'h80000000;
          2: d = 32'($urandom_range(1 << 20)) - 32'd524288;
          default: d = $urandom;
        endcase
        write_reg(CFG_BIAS, d);
      end
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(11))
          0: d = 32'd1024;
          1: d = 32'd0;
          2: d = 32'h7FF;
          3: d = 32'd1;
          default: d = $urandom_range(12, 1);
        endcase
        if ($urandom_range(3) == 0) d[31:11] = 21'($urandom);
        write_reg(CFG_WIDTH, d);
      end
      fw = clamp_dim(width_img, WMAX);
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(11))
          0: d = (fw == 1) ? 32'd1024 : 32'd1;
          1: d = 32'd0;
          2: d = (fw == 1) ? 32'h7FF : 32'd2;
          default: d = (fw > 64) ? $urandom_range(2, 1) : $urandom_range(12, 1);
        endcase
        write_reg(CFG_HEIGHT, d);
      end
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(7))
          0: d = 32'd11;
          1: d = 32'd0;
          2: d = $urandom_range(15, 12);
          default: d = $urandom_range(5, 1);
        endcase
        write_reg(CFG_KERNEL, d);
      end
      fw = clamp_dim(width_img, WMAX);
      fh = clamp_dim(height_img, 1024);
      npix = fw * fh;
      if (npix < 200) npix = npix * $urandom_range(3, 1);
      if ($urandom_range(3) == 0) npix = npix + $urandom_range(fw * fh - 1);
      if (npix > RANDOM_ITEMS - sent) npix = RANDOM_ITEMS - sent + 1;
      for (int n = 0; n < npix; n++) begin
        if ($urandom_range(99) < 8)
          send_req(CMD_WEIGHT, 4'($urandom), 4'($urandom), pick_sample());
        send_req(CMD_PIXEL, 4'($urandom), 4'($urandom), pick_sample());
      end
    end

    drain();
    if (errors == 0 && pending_q.size() == 0) begin
      $display("tb_conv2d_bias_relu: done, clean");
    end else begin
      $display("tb_conv2d_bias_relu: done, errors");
    end
    $finish;
  end

endmodule
